[design/fdd_pkg.sv]
`default_nettype none

package fdd_pkg;

    // sample and output width
    localparam int SAMPLE_W = 16;

    // default filter configuration
    localparam int FILTER_ORDER_DEF   = 178;
    localparam int COEF_FRAC_BITS_DEF = 17;

    // symmetric prototype: 181 taps, centre at 90, values in millionths
    localparam int PROTO_CENTRE = 90;
    localparam int PROTO_LAST   = 180;
    localparam int MICRO_SCALE  = 1000000;

    localparam int PROTO_MICRO [PROTO_CENTRE+1] = '{
        200, -150, -279, 24, 309, 125, -276, -273, 172, 392,
        0, -445, -222, 398, 454, -230, -637, -54, 706, 416,
        -603, -779, 302, 1044, 175, -1105, -751, 885, 1294, -361,
        -1645, -408, 1655, 1280, -1229, -2046, 367, 2474, 811, -2365,
        -2071, 1616, 3103, -270, -3581, -1462, 3255, 3220, -2024, -4560,
        0, 5045, 2477, -4362, -4880, 2427, 6587, 550, -7017, -4056,
        5777, 7335, -2801, -9525, -1577, 9831, 6610, -7726, -11228, 3121,
        14203, 3530, -14373, -11205, 10877, 18398, -3365, -23275, -7871, 23848,
        21885, -18065, -37169, 3519, 51875, 24193, -64095, -80483, 72178, 309445,
        425024
    };

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_DONE
    } t_state;

    // control travelling with one tap through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic use_x;
        logic zero;
    } t_mac_ctl;

    // quantised prototype tap, round to nearest with ties away from zero;
    // only ever called with constant arguments
    function automatic longint fdd_coef(input int p, input int frac);
        longint mag;
        longint q;
        int     idx;
        if (p < 0 || p > PROTO_LAST) begin
            return 0;
        end
        idx = (p > PROTO_CENTRE) ? (PROTO_LAST - p) : p;
        mag = (PROTO_MICRO[idx] < 0) ? -longint'(PROTO_MICRO[idx])
                                     : longint'(PROTO_MICRO[idx]);
        q = ((mag << frac) + (MICRO_SCALE / 2)) / MICRO_SCALE;
        return (PROTO_MICRO[idx] < 0) ? -q : q;
    endfunction

endpackage

`default_nettype wire

[design/fdd_ram.sv]
`default_nettype none

module fdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 178
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[design/fdd_mac.sv]
`default_nettype none

module fdd_mac #(
    parameter int CW    = 18,
    parameter int ACC_W = 42,
    parameter int FRAC  = 17
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fdd_pkg::t_mac_ctl               i_ctl,
    input  wire logic signed [fdd_pkg::SAMPLE_W-1:0] i_x,
    input  wire logic signed [CW-1:0]            i_coef,
    input  wire logic signed [fdd_pkg::SAMPLE_W-1:0] i_rd_data,
    output logic                                 o_done,
    output logic signed [fdd_pkg::SAMPLE_W-1:0]  o_result
);

    import fdd_pkg::*;

    localparam int PW = SAMPLE_W + CW;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    t_mac_ctl                   r_s1;
    t_mac_ctl                   r_s2;
    logic signed [CW-1:0]       r_s1_coef;
    logic signed [SAMPLE_W-1:0] w_s1_data;
    logic signed [PW-1:0]       r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    w_shift;
    logic                       r_done;

    // stage 1: coefficient registered, RAM data arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= i_ctl;
        end
        r_s1_coef <= i_coef;
    end

    // newest sample, stored history, or zero for history not yet filled
    always_comb begin
        if (r_s1.use_x) begin
            w_s1_data = i_x;
        end else if (r_s1.zero) begin
            w_s1_data = '0;
        end else begin
            w_s1_data = i_rd_data;
        end
    end

    // stage 2: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= r_s1;
        end
        r_prod <= w_s1_data * r_s1_coef;
    end

    // stage 3: accumulate, restart on the first tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2.valid && r_s2.last;
        end
        if (r_s2.valid) begin
            if (r_s2.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // floor by arithmetic shift, then saturate
    assign w_shift = r_acc >>> FRAC;

    always_comb begin
        if (w_shift > SAT_HI) begin
            o_result = 16'sh7fff;
        end else if (w_shift < SAT_LO) begin
            o_result = 16'sh8000;
        end else begin
            o_result = w_shift[SAMPLE_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

[design/fir_decimate_by_two.sv]
// Low-pass FIR (FILTER_ORDER+1 symmetric taps, fixed coefficients with
// COEF_FRAC_BITS fraction bits) followed by a 2:1 decimator. Every input
// beat advances the filter history; the first result after reset or after
// a beat with restart set is delivered, then every second one. A single
// multiply-accumulate unit steps through the taps, one per cycle; for each
// beat the block takes the beat, walks every tap, drains the MAC pipeline
// and hands the result to the output register, and it takes no new beat
// until that is done. o_stall is low only while the sequencer is idle and
// high from a taken beat until its result is handed on or dropped. A kept
// result that finds the output register still full and held by i_stall
// waits in that last step, which lengthens the beat. The
// history lives in a circular RAM; entries not yet written since reset
// read as zero through a fill count, so no clearing pass is needed. A
// finished result waits in the output register while the next beat is
// taken.
`default_nettype none

module fir_decimate_by_two #(
    parameter int FILTER_ORDER   = fdd_pkg::FILTER_ORDER_DEF,
    parameter int COEF_FRAC_BITS = fdd_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [fdd_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_restart,
    output logic                                     o_stall,
    output logic                                     o_valid,
    output logic signed [fdd_pkg::SAMPLE_W-1:0]      o_filtered_sample,
    input  wire logic                                i_stall
);

    import fdd_pkg::*;

    localparam int CW    = COEF_FRAC_BITS + 1;
    localparam int TW    = $clog2(FILTER_ORDER + 1);
    localparam int AW    = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
    localparam int ACC_W = SAMPLE_W + CW + TW;
    localparam logic [TW-1:0] LAST_TAP = TW'(FILTER_ORDER);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FILTER_ORDER - 1);

    t_state                     r_state;
    t_state                     n_state;
    logic [TW-1:0]              r_tap;
    logic [TW-1:0]              r_fill;
    logic [AW-1:0]              r_wp;
    logic [AW-1:0]              r_rp;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_keep;
    logic                       r_phase;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       w_in_beat;
    logic                       w_out_free;
    logic                       w_ram_we;
    logic                       w_out_load;
    t_mac_ctl                   w_ctl;
    logic signed [CW-1:0]       w_coef;
    logic signed [SAMPLE_W-1:0] w_rd_data;
    logic                       w_mac_done;
    logic signed [SAMPLE_W-1:0] w_mac_result;

    // coefficient table, fixed at elaboration
    logic signed [CW-1:0] w_coef_tab [FILTER_ORDER+1];

    for (genvar k = 0; k <= FILTER_ORDER; k++) begin : g_coef
        localparam logic signed [CW-1:0] C =
            CW'(fdd_coef(k - FILTER_ORDER / 2 + PROTO_CENTRE, COEF_FRAC_BITS));
        assign w_coef_tab[k] = C;
    end

    assign w_coef     = w_coef_tab[r_tap];
    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_tap == LAST_TAP) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (w_mac_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_keep || w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ctl      = '0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_RUN: begin
                w_ctl.valid = 1'b1;
                w_ctl.first = (r_tap == '0);
                w_ctl.last  = (r_tap == LAST_TAP);
                w_ctl.use_x = (r_tap == '0);
                w_ctl.zero  = (r_tap > r_fill);
            end
            S_FLUSH: begin
                w_ram_we = w_mac_done;
            end
            S_DONE: begin
                w_out_load = r_keep && w_out_free;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    // state, tap walk and history pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_phase <= 1'b0;
            r_keep  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_beat) begin
                r_tap   <= '0;
                r_rp    <= (r_wp == '0) ? LAST_ADDR : r_wp - 1'b1;
                r_keep  <= i_restart || !r_phase;
                r_phase <= i_restart || !r_phase;
            end else if (r_state == S_RUN) begin
                r_tap <= r_tap + 1'b1;
                if (r_tap != '0) begin
                    r_rp <= (r_rp == '0) ? LAST_ADDR : r_rp - 1'b1;
                end
            end
            if (w_ram_we) begin
                r_wp <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                if (r_fill != LAST_TAP) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // held sample for the whole beat
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_x <= i_sample;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out_data <= w_mac_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_out_data;

    // filter history, circular
    fdd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FILTER_ORDER)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_wp),
        .i_wr_data (r_x),
        .i_rd_addr (r_rp),
        .o_rd_data (w_rd_data)
    );

    // shared multiply-accumulate unit
    fdd_mac #(
        .CW    (CW),
        .ACC_W (ACC_W),
        .FRAC  (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_x       (r_x),
        .i_coef    (w_coef),
        .i_rd_data (w_rd_data),
        .o_done    (w_mac_done),
        .o_result  (w_mac_result)
    );

endmodule

`default_nettype wire
